### rtl/gcl_pkg.sv
package gcl_pkg;

    // Default operand width and the fixed width of the answer field.
    localparam int OPERAND_WIDTH_DEF = 31;
    localparam int ANSWER_WIDTH      = 62;

endpackage

### rtl/gcl_addsub.sv
module gcl_addsub #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_carry
);

    logic [WIDTH-1:0] w_y;

    // For a subtraction the carry out is set when i_x >= i_y.
    assign w_y = i_sub ? ~i_y : i_y;
    assign {o_carry, o_sum} = {1'b0, i_x} + {1'b0, w_y} + (WIDTH+1)'(i_sub);

endmodule

### rtl/gcd_lcm_unit_core.sv
// GCD / LCM unit. A transaction is taken when start is high and busy is low;
// busy then stays high until the answer is ready. The answer appears on
// o_answer for exactly one cycle, flagged by o_done, and must be captured in
// that cycle since the unit cannot be stalled. A zero operand gives an answer
// of 0 in the cycle after start, with busy never raised. Otherwise all work
// runs through one shared adder/subtractor of OPERAND_WIDTH+1 bits: binary
// GCD (shifts, swaps and subtractions), then restoring the common power of
// two, and for an LCM a serial divide by the GCD and a shift-add multiply.
// Busy drops in the same cycle that o_done is shown.
module gcd_lcm_unit_core
    import gcl_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OPERAND_WIDTH-1:0] i_first_value,
    input  logic [OPERAND_WIDTH-1:0] i_second_value,
    input  logic                     i_action,
    output logic                     o_done,
    output logic [ANSWER_WIDTH-1:0]  o_answer
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(OPERAND_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TWOS,
        S_ODDA,
        S_EUCL,
        S_SHL,
        S_DIV,
        S_MUL
    } t_state;

    t_state                  r_state, n_state;
    logic [W-1:0]            r_a, n_a;
    logic [W-1:0]            r_b, n_b;
    logic [W-1:0]            r_first, n_first;
    logic [W-1:0]            r_second, n_second;
    logic                    r_lcm, n_lcm;
    logic [CW-1:0]           r_twos, n_twos;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic                    r_done, n_done;
    logic [ANSWER_WIDTH-1:0] r_answer, n_answer;

    logic [W:0]              w_x, w_y, w_sum;
    logic                    w_sub, w_carry;
    logic [W:0]              w_hi;
    logic [2*W-1:0]          w_prod;
    logic [ANSWER_WIDTH-1:0] w_prod_ans, w_gcd_ans;

    gcl_addsub #(
        .WIDTH(W + 1)
    ) u_addsub (
        .i_x    (w_x),
        .i_y    (w_y),
        .i_sub  (w_sub),
        .o_sum  (w_sum),
        .o_carry(w_carry)
    );

    // Operand selection for the shared adder.
    always_comb begin
        w_x   = {1'b0, r_b};
        w_y   = {1'b0, r_a};
        w_sub = 1'b1;
        case (r_state)
            S_DIV: begin
                w_x = {r_b, r_first[W-1]};
            end
            S_MUL: begin
                w_y   = {1'b0, r_second};
                w_sub = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Multiply step: add the multiplicand when the low multiplier bit is set.
    assign w_hi   = r_first[0] ? w_sum : {1'b0, r_b};
    assign w_prod = {w_hi, r_first[W-1:1]};

    generate
        if (2 * W >= ANSWER_WIDTH) begin : g_trunc
            assign w_prod_ans = w_prod[ANSWER_WIDTH-1:0];
        end else begin : g_ext
            assign w_prod_ans = {{(ANSWER_WIDTH - 2 * W){1'b0}}, w_prod};
        end
    endgenerate

    assign w_gcd_ans = {{(ANSWER_WIDTH - W){1'b0}}, r_a};

    always_comb begin
        n_state  = r_state;
        n_a      = r_a;
        n_b      = r_b;
        n_first  = r_first;
        n_second = r_second;
        n_lcm    = r_lcm;
        n_twos   = r_twos;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_answer = r_answer;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_a      = i_first_value;
                    n_b      = i_second_value;
                    n_first  = i_first_value;
                    n_second = i_second_value;
                    n_lcm    = i_action;
                    n_twos   = '0;
                    if (i_first_value == '0 || i_second_value == '0) begin
                        n_done   = 1'b1;
                        n_answer = '0;
                    end else begin
                        n_state = S_TWOS;
                    end
                end
            end
            S_TWOS: begin
                if (!(r_a[0] | r_b[0])) begin
                    n_a    = r_a >> 1;
                    n_b    = r_b >> 1;
                    n_twos = r_twos + CW'(1);
                end else begin
                    n_state = S_ODDA;
                end
            end
            S_ODDA: begin
                if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else begin
                    n_state = S_EUCL;
                end
            end
            S_EUCL: begin
                if (r_b == '0) begin
                    n_state = S_SHL;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (w_carry) begin
                    n_b = w_sum[W-1:0];
                end else begin
                    // Swap so that the smaller odd value sits in r_a.
                    n_a = r_b;
                    n_b = r_a;
                end
            end
            S_SHL: begin
                if (r_twos != '0) begin
                    n_a    = r_a << 1;
                    n_twos = r_twos - CW'(1);
                end else if (!r_lcm) begin
                    n_done   = 1'b1;
                    n_answer = w_gcd_ans;
                    n_state  = S_IDLE;
                end else begin
                    n_b     = '0;
                    n_cnt   = CW'(W);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // Restoring division of r_first by the GCD in r_a.
                n_b     = w_carry ? w_sum[W-1:0] : w_x[W-1:0];
                n_first = {r_first[W-2:0], w_carry};
                n_cnt   = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_b     = '0;
                    n_cnt   = CW'(W);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_b     = w_hi[W:1];
                n_first = {w_hi[0], r_first[W-1:1]};
                n_cnt   = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_done   = 1'b1;
                    n_answer = w_prod_ans;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_a      <= n_a;
        r_b      <= n_b;
        r_first  <= n_first;
        r_second <= n_second;
        r_lcm    <= n_lcm;
        r_twos   <= n_twos;
        r_cnt    <= n_cnt;
        r_answer <= n_answer;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_answer = r_answer;

endmodule

### rtl/gcl_checker.sv
module gcl_checker
    import gcl_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [OPERAND_WIDTH-1:0] i_first_value,
    input logic [OPERAND_WIDTH-1:0] i_second_value,
    input logic                     i_action,
    input logic                     o_done,
    input logic [ANSWER_WIDTH-1:0]  o_answer
);

    // A zero operand is answered with 0 in the next cycle.
    a_zero_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_first_value == '0 || i_second_value == '0)
        |=> o_done && o_answer == '0 && !busy)
        else $error("zero operand not answered with 0");

    // Nonzero operands start a multi-cycle transaction.
    a_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_first_value != '0 && i_second_value != '0
        |=> busy && !o_done)
        else $error("transaction with nonzero operands did not raise busy");

    // The answer is never shown while the unit is still working.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // When busy falls, the finished transaction delivers its result in that cycle.
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

endmodule

bind gcd_lcm_unit_core gcl_checker #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
) u_gcl_checker (.*);

### tb/gcd_lcm_unit_core_tb.sv
module gcd_lcm_unit_core_tb
    import gcl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OW = OPERAND_WIDTH_DEF;
    localparam logic [OW-1:0] OPERAND_MAX = '1;
    localparam logic ACT_GCD = 1'b0;
    localparam logic ACT_LCM = 1'b1;
    localparam int DRAIN_LIMIT = 4000;
    localparam int TAIL_CYCLES = 10 * OW;

    class answer_checker;
        logic [ANSWER_WIDTH-1:0] pending_answers[$];
        int unsigned checked;
        int unsigned mismatches;
        int unsigned gcd_count;
        int unsigned lcm_count;
        int unsigned zero_count;

        // Binary GCD, then (a / g) * b at the full answer width for the LCM.
        function logic [ANSWER_WIDTH-1:0] gcd_lcm_of(logic [OW-1:0] a, logic [OW-1:0] b,
                                                     logic want_lcm);
            logic [OW-1:0] x;
            logic [OW-1:0] y;
            logic [OW-1:0] t;
            logic [OW-1:0] g;
            int twos;
            logic [ANSWER_WIDTH-1:0] r;
            r = '0;
            if (a != '0 && b != '0) begin
                x = a;
                y = b;
                twos = 0;
                while (x[0] == 1'b0 && y[0] == 1'b0) begin
                    x = x >> 1;
                    y = y >> 1;
                    twos++;
                end
                while (x[0] == 1'b0) x = x >> 1;
                while (y != '0) begin
                    while (y[0] == 1'b0) y = y >> 1;
                    if (x > y) begin
                        t = x;
                        x = y;
                        y = t;
                    end
                    y = y - x;
                end
                g = x << twos;
                if (want_lcm) r = ANSWER_WIDTH'(a / g) * ANSWER_WIDTH'(b);
                else r = ANSWER_WIDTH'(g);
            end
            return r;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_operands(logic [OW-1:0] a, logic [OW-1:0] b, logic act);
            pending_answers.push_back(gcd_lcm_of(a, b, act));
            if (act == ACT_LCM) lcm_count++;
            else gcd_count++;
            if (a == '0 || b == '0) zero_count++;
        endfunction

        task check_answer(logic [ANSWER_WIDTH-1:0] got);
            logic [ANSWER_WIDTH-1:0] want;
            checked++;
            if (pending_answers.size() == 0) begin
                report($sformatf("answer 0x%0h with no transaction pending", got));
            end else begin
                want = pending_answers.pop_front();
                if (got !== want)
                    report($sformatf("answer 0x%0h, expected 0x%0h", got, want));
            end
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [OW-1:0]           i_first_value;
    logic [OW-1:0]           i_second_value;
    logic                    i_action;
    logic                    o_done;
    logic [ANSWER_WIDTH-1:0] o_answer;

    answer_checker board = new();

    gcd_lcm_unit_core #(
        .OPERAND_WIDTH(OW)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_first_value (i_first_value),
        .i_second_value(i_second_value),
        .i_action      (i_action),
        .o_done        (o_done),
        .o_answer      (o_answer)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Both outputs and inputs are read before this edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) board.check_answer(o_answer);
            if (start && !busy) board.note_operands(i_first_value, i_second_value, i_action);
        end
    end

    // Holds start high until the unit takes the transaction; start is left high.
    task automatic send_item(input logic [OW-1:0] a, input logic [OW-1:0] b,
                             input logic act);
        start          <= 1'b1;
        i_first_value  <= a;
        i_second_value <= b;
        i_action       <= act;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        start          <= 1'b0;
        i_first_value  <= OW'($urandom);
        i_second_value <= OW'($urandom);
        i_action       <= 1'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pick_operands(output logic [OW-1:0] a, output logic [OW-1:0] b,
                                 output logic act);
        int unsigned g;
        act = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                a = OW'($urandom);
                b = OW'($urandom);
            end
            3, 4: begin
                g = $urandom_range(1, 65535);
                a = OW'(g * $urandom_range(1, 32767));
                b = OW'(g * $urandom_range(1, 32767));
            end
            5: begin
                a = OW'($urandom) << $urandom_range(0, OW - 1);
                b = OW'($urandom) << $urandom_range(0, OW - 1);
            end
            6: begin
                a = OW'($urandom_range(0, 300));
                b = OW'($urandom_range(0, 300));
            end
            7: begin
                a = OW'($urandom);
                b = '0;
                if ($urandom_range(0, 1) == 1) begin
                    b = a;
                    a = '0;
                end
            end
            8: begin
                a = OW'($urandom_range(1, 1 << 20));
                b = OW'(a * $urandom_range(1, 1000));
                if (b == '0) b = a;
            end
            default: begin
                a = OPERAND_MAX - OW'($urandom_range(0, 1000));
                b = OPERAND_MAX - OW'($urandom_range(0, 1000));
            end
        endcase
    endtask

    initial begin
        logic [OW-1:0] a;
        logic [OW-1:0] b;
        logic act;
        int burst_left;
        int waited;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_first_value  = '0;
        i_second_value = '0;
        i_action       = ACT_GCD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero operands, the extremes, powers of two and large coprime pairs.
        send_item('0, '0, ACT_GCD);
        send_item('0, '0, ACT_LCM);
        send_item('0, OPERAND_MAX, ACT_GCD);
        send_item(OPERAND_MAX, '0, ACT_LCM);
        send_item(OW'(1), OW'(1), ACT_GCD);
        send_item(OW'(1), OW'(1), ACT_LCM);
        send_item(OPERAND_MAX, OPERAND_MAX, ACT_GCD);
        send_item(OPERAND_MAX, OPERAND_MAX, ACT_LCM);
        send_item(OPERAND_MAX, OPERAND_MAX - OW'(1), ACT_LCM);
        send_item(OPERAND_MAX, OPERAND_MAX - OW'(1), ACT_GCD);
        send_item(OW'(1), OPERAND_MAX, ACT_LCM);
        send_item(31'd2147483629, OPERAND_MAX, ACT_LCM);
        send_item(31'd2147483629, OPERAND_MAX, ACT_GCD);
        send_item(31'h4000_0000, 31'h2000_0000, ACT_GCD);
        send_item(31'h4000_0000, 31'h6000_0000, ACT_LCM);
        send_item(31'h4000_0000, OW'(1), ACT_LCM);
        send_item(31'h4000_0000, OPERAND_MAX, ACT_LCM);
        send_item(31'h5555_5555, 31'h2AAA_AAAA, ACT_GCD);
        send_item(31'h5555_5555, 31'h2AAA_AAAA, ACT_LCM);
        idle_cycles(3);
        send_item(OW'(12), OW'(18), ACT_GCD);
        send_item(OW'(12), OW'(18), ACT_LCM);
        send_item(OW'(7), OW'(3), ACT_GCD);
        idle_cycles(1);

        burst_left = 0;
        for (int i = 0; i < 1500; i++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                         : $urandom_range(1, 20);
                case ($urandom_range(0, 5))
                    0, 1:    ;
                    2:       idle_cycles($urandom_range(20, 300));
                    default: idle_cycles($urandom_range(1, 15));
                endcase
            end
            pick_operands(a, b, act);
            send_item(a, b, act);
            burst_left--;
        end
        idle_cycles(1);

        waited = 0;
        while (board.pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.pending_answers.size() != 0)
            board.report($sformatf("%0d answers never arrived",
                                   board.pending_answers.size()));

        $display("covered %0d transactions: %0d gcd, %0d lcm, %0d with a zero operand",
                 board.gcd_count + board.lcm_count, board.gcd_count, board.lcm_count,
                 board.zero_count);
        $display("%0d answers checked, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0) begin
            $display("gcd_lcm_unit_core regression: pass");
        end else begin
            $display("gcd_lcm_unit_core regression: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d answers outstanding", board.pending_answers.size());
        $display("gcd_lcm_unit_core regression: fail");
        $finish;
    end

endmodule
